// ===== hw/rtl/plab_pkg.sv =====
// ----------------------------------------------------------------------------
// plab_pkg: shared types and constants
// Request and status codes, slot limit and the operand and result words of
// the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package plab_pkg;

	localparam logic [2:0] MAX_SLOTS = 3'd7;
	localparam logic [6:0] DIR_SCALE = 7'd120;

	localparam int ALU_SUB_W = 45;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_POINT = 2'd1;
	localparam logic [1:0] REQ_DIR   = 2'd2;

	localparam logic [1:0] ST_BOUND = 2'd0;
	localparam logic [1:0] ST_SKIP  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	typedef struct packed {
		logic [31:0]          mul_a;
		logic [31:0]          mul_b;
		logic [ALU_SUB_W-1:0] sub_a;
		logic [ALU_SUB_W-1:0] sub_b;
	} alu_req_t;

	typedef struct packed {
		logic [63:0]          prod;
		logic [ALU_SUB_W-1:0] diff;
		logic                 ge;
	} alu_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/plab_alu.sv =====
// ----------------------------------------------------------------------------
// plab_alu: shared arithmetic unit
// One unsigned 32x32 multiplier and one compare-subtract, used by the
// squaring, colour and direction steps of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module plab_alu (
	input  plab_pkg::alu_req_t req,
	output plab_pkg::alu_rsp_t rsp
);
	import plab_pkg::*;

	logic [ALU_SUB_W:0] sub_full;

	assign sub_full = {1'b0, req.sub_a} - {1'b0, req.sub_b};

	assign rsp.prod = req.mul_a * req.mul_b;
	assign rsp.diff = sub_full[ALU_SUB_W-1:0];
	assign rsp.ge   = ~sub_full[ALU_SUB_W];

endmodule
`default_nettype wire

// ===== hw/rtl/point_light_attenuate_bind_unit.sv =====
// ----------------------------------------------------------------------------
// point_light_attenuate_bind_unit: light group binder
// Sequencer around one shared multiplier/subtractor that binds point and
// directional lights into slots, attenuating colour and normalizing direction.
// ----------------------------------------------------------------------------
// Clear, directional and early-rejected point requests go straight to output.
// Other points square offsets and radius and check the range; a bound point
// then divides each colour bit by bit and, unless it sits at the reference,
// searches each direction component bit by bit. One item at a time; the next
// word is accepted while a result waits at the output register.
// Reset clears the slot count, the sequencer and the output valid.
`default_nettype none
module point_light_attenuate_bind_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic signed [15:0] light_x,
	input  wire logic signed [15:0] light_y,
	input  wire logic signed [15:0] light_z,
	input  wire logic [7:0]        color_r,
	input  wire logic [7:0]        color_g,
	input  wire logic [7:0]        color_b,
	input  wire logic signed [15:0] light_radius,
	input  wire logic              ref_present,
	input  wire logic signed [15:0] ref_x,
	input  wire logic signed [15:0] ref_y,
	input  wire logic signed [15:0] ref_z,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [1:0]             status,
	output logic [2:0]             slot_index,
	output logic [7:0]             out_r,
	output logic [7:0]             out_g,
	output logic [7:0]             out_b,
	output logic signed [7:0]      dir_x,
	output logic signed [7:0]      dir_y,
	output logic signed [7:0]      dir_z
);
	import plab_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_SQ   = 11'b000_0000_0010,
		S_CHK  = 11'b000_0000_0100,
		S_CMUL = 11'b000_0000_1000,
		S_CDIV = 11'b000_0001_0000,
		S_DNUM = 11'b000_0010_0000,
		S_DNSQ = 11'b000_0100_0000,
		S_DCSQ = 11'b000_1000_0000,
		S_DPRD = 11'b001_0000_0000,
		S_DCMP = 11'b010_0000_0000,
		S_OUT  = 11'b100_0000_0000
	} state_t;

	state_t      st_q;
	logic [2:0]  slots_q;
	logic [1:0]  cnt_q;
	logic [2:0]  bit_q;
	logic [15:0] rad_q;
	logic [7:0]  col_q [3];
	logic [15:0] adf_q [3];
	logic [2:0]  sgn_q;
	logic [33:0] d2_q;
	logic [29:0] r2_q;
	logic [29:0] att_q;
	logic [37:0] rem_q;
	logic [36:0] dv_q;
	logic [7:0]  quot_q;
	logic [21:0] num_q;
	logic [43:0] n2_q;
	logic [13:0] c2_q;
	logic [43:0] p_q;
	logic [6:0]  q_q;

	logic [1:0]  rs_status_q;
	logic [2:0]  rs_slot_q;
	logic [7:0]  rs_col_q [3];
	logic [7:0]  rs_dir_q [3];

	logic        res_valid_q;
	logic [1:0]  status_q;
	logic [2:0]  slot_q;
	logic [7:0]  outc_q [3];
	logic [7:0]  outd_q [3];

	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;

	logic        acc;
	logic        load_out;
	logic [16:0] dfull [3];
	logic [6:0]  cand;
	logic [6:0]  qfin;
	logic [15:0] sq_op;

	plab_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign req_stall = (st_q != S_IDLE);
	assign acc       = req_valid & ~req_stall;
	assign load_out  = (st_q == S_OUT) & (~res_valid_q | ~res_stall);

	assign dfull[0] = {light_x[15], light_x} - {ref_x[15], ref_x};
	assign dfull[1] = {light_y[15], light_y} - {ref_y[15], ref_y};
	assign dfull[2] = {light_z[15], light_z} - {ref_z[15], ref_z};

	assign cand  = q_q | (7'd1 << bit_q);
	assign qfin  = alu_rsp.ge ? cand : q_q;
	assign sq_op = (cnt_q == 2'd3) ? rad_q : adf_q[cnt_q];

	always_comb begin
		alu_req = '0;
		unique case (st_q)
			S_SQ: begin
				alu_req.mul_a = {16'd0, sq_op};
				alu_req.mul_b = {16'd0, sq_op};
			end
			S_CMUL: begin
				alu_req.mul_a = {24'd0, col_q[cnt_q]};
				alu_req.mul_b = {2'd0, att_q};
			end
			S_CDIV: begin
				alu_req.sub_a = {7'd0, rem_q};
				alu_req.sub_b = {8'd0, dv_q};
			end
			S_DNUM: begin
				alu_req.mul_a = {16'd0, adf_q[cnt_q]};
				alu_req.mul_b = {25'd0, DIR_SCALE};
			end
			S_DNSQ: begin
				alu_req.mul_a = {10'd0, num_q};
				alu_req.mul_b = {10'd0, num_q};
			end
			S_DCSQ: begin
				alu_req.mul_a = {25'd0, cand};
				alu_req.mul_b = {25'd0, cand};
			end
			S_DPRD: begin
				alu_req.mul_a = {18'd0, c2_q};
				alu_req.mul_b = {2'd0, d2_q[29:0]};
			end
			S_DCMP: begin
				alu_req.sub_a = {1'b0, n2_q};
				alu_req.sub_b = {1'b0, p_q};
			end
			default: begin
			end
		endcase
	end

	// sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			slots_q <= '0;
			cnt_q   <= '0;
			bit_q   <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (acc) begin
						rad_q    <= light_radius;
						col_q[0] <= color_r;
						col_q[1] <= color_g;
						col_q[2] <= color_b;
						for (int i = 0; i < 3; i++) begin
							sgn_q[i]    <= dfull[i][16];
							adf_q[i]    <= dfull[i][16] ? 16'(-dfull[i]) : dfull[i][15:0];
							rs_col_q[i] <= '0;
							rs_dir_q[i] <= '0;
						end
						d2_q        <= '0;
						cnt_q       <= '0;
						rs_status_q <= ST_SKIP;
						rs_slot_q   <= '0;
						st_q        <= S_OUT;
						unique case (req_type)
							REQ_CLEAR: begin
								slots_q     <= '0;
								rs_status_q <= ST_CLEAR;
							end
							REQ_DIR: begin
								if (slots_q >= MAX_SLOTS) begin
									rs_status_q <= ST_FULL;
								end else begin
									rs_status_q <= ST_BOUND;
									rs_slot_q   <= slots_q;
									slots_q     <= slots_q + 3'd1;
									rs_col_q[0] <= color_r;
									rs_col_q[1] <= color_g;
									rs_col_q[2] <= color_b;
									rs_dir_q[0] <= light_x[7:0];
									rs_dir_q[1] <= light_y[7:0];
									rs_dir_q[2] <= light_z[7:0];
								end
							end
							REQ_POINT: begin
								if (ref_present && !light_radius[15] && light_radius != 16'sd0) begin
									st_q <= S_SQ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SQ: begin
					if (cnt_q == 2'd3) begin
						r2_q  <= alu_rsp.prod[29:0];
						cnt_q <= '0;
						st_q  <= S_CHK;
					end else begin
						d2_q  <= d2_q + {2'd0, alu_rsp.prod[31:0]};
						cnt_q <= cnt_q + 2'd1;
					end
				end
				S_CHK: begin
					if ({4'd0, r2_q} > d2_q) begin
						if (slots_q >= MAX_SLOTS) begin
							rs_status_q <= ST_FULL;
							st_q        <= S_OUT;
						end else begin
							rs_status_q <= ST_BOUND;
							rs_slot_q   <= slots_q;
							slots_q     <= slots_q + 3'd1;
							att_q       <= r2_q - d2_q[29:0];
							st_q        <= S_CMUL;
						end
					end else begin
						st_q <= S_OUT;
					end
				end
				S_CMUL: begin
					rem_q  <= alu_rsp.prod[37:0];
					dv_q   <= {r2_q, 7'd0};
					quot_q <= '0;
					bit_q  <= 3'd7;
					st_q   <= S_CDIV;
				end
				S_CDIV: begin
					if (alu_rsp.ge) begin
						rem_q <= alu_rsp.diff[37:0];
					end
					quot_q <= {quot_q[6:0], alu_rsp.ge};
					dv_q   <= dv_q >> 1;
					if (bit_q == 3'd0) begin
						rs_col_q[cnt_q] <= {quot_q[6:0], alu_rsp.ge};
						if (cnt_q == 2'd2) begin
							cnt_q <= '0;
							st_q  <= S_DNUM;
						end else begin
							cnt_q <= cnt_q + 2'd1;
							st_q  <= S_CMUL;
						end
					end else begin
						bit_q <= bit_q - 3'd1;
					end
				end
				S_DNUM: begin
					// point at the reference: directions stay zero
					if (d2_q == 34'd0) begin
						st_q <= S_OUT;
					end else begin
						num_q <= alu_rsp.prod[21:0];
						q_q   <= '0;
						bit_q <= 3'd6;
						st_q  <= S_DNSQ;
					end
				end
				S_DNSQ: begin
					n2_q <= alu_rsp.prod[43:0];
					st_q <= S_DCSQ;
				end
				S_DCSQ: begin
					c2_q <= alu_rsp.prod[13:0];
					st_q <= S_DPRD;
				end
				S_DPRD: begin
					p_q  <= alu_rsp.prod[43:0];
					st_q <= S_DCMP;
				end
				S_DCMP: begin
					q_q <= qfin;
					if (bit_q == 3'd0) begin
						rs_dir_q[cnt_q] <= sgn_q[cnt_q] ? 8'(-{1'b0, qfin}) : {1'b0, qfin};
						if (cnt_q == 2'd2) begin
							st_q <= S_OUT;
						end else begin
							cnt_q <= cnt_q + 2'd1;
							st_q  <= S_DNUM;
						end
					end else begin
						bit_q <= bit_q - 3'd1;
						st_q  <= S_DCSQ;
					end
				end
				S_OUT: begin
					if (load_out) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= rs_status_q;
			slot_q   <= rs_slot_q;
			outc_q   <= rs_col_q;
			outd_q   <= rs_dir_q;
		end
	end

	assign res_valid  = res_valid_q;
	assign status     = status_q;
	assign slot_index = slot_q;
	assign out_r      = outc_q[0];
	assign out_g      = outc_q[1];
	assign out_b      = outc_q[2];
	assign dir_x      = outd_q[0];
	assign dir_y      = outd_q[1];
	assign dir_z      = outd_q[2];

	a_slots_max: assert property (@(posedge clk) disable iff (!arst_n)
		slots_q <= MAX_SLOTS)
		else $error("slot count beyond limit");

	a_unbound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != ST_BOUND) |->
		(slot_index == 3'd0 && out_r == 8'd0 && out_g == 8'd0 && out_b == 8'd0 &&
		 dir_x == 8'sd0 && dir_y == 8'sd0 && dir_z == 8'sd0))
		else $error("unbound result carries data");

	a_dir_nonzero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DCMP) |-> (d2_q != 34'd0))
		else $error("direction search at zero distance");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(st_q == S_OUT))
		else $error("result raised outside output step");

endmodule
`default_nettype wire

// ===== bench/point_light_attenuate_bind_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_light_attenuate_bind_unit_tb: light group binder bench
// Drives clear, point, directional and unused-code requests through the
// valid/stall channels. Each result word is checked against an in-bench
// attenuation and direction calculator and a slot counter.
// ----------------------------------------------------------------------------
module point_light_attenuate_bind_unit_tb;
	import plab_pkg::*;

	typedef struct {
		logic [1:0] rt;
		logic signed [15:0] lx, ly, lz;
		logic [7:0] cr, cg, cb;
		logic signed [15:0] rad;
		logic rp;
		logic signed [15:0] rx, ry, rz;
	} light_req_t;

	typedef struct {
		logic [1:0] st;
		logic [2:0] slot;
		logic [7:0] r, g, b;
		logic signed [7:0] dx, dy, dz;
	} slot_word_t;

	logic clk, arst_n;
	logic req_valid, req_stall, res_valid, res_stall;
	logic [1:0] req_type;
	logic signed [15:0] light_x, light_y, light_z, light_radius, ref_x, ref_y, ref_z;
	logic [7:0] color_r, color_g, color_b;
	logic ref_present;
	logic [1:0] status;
	logic [2:0] slot_index;
	logic [7:0] out_r, out_g, out_b;
	logic signed [7:0] dir_x, dir_y, dir_z;

	point_light_attenuate_bind_unit DUT (.*);

	slot_word_t bound_q[$];
	logic [2:0] used_slots;
	int errors, n_seen, n_bound, n_full, n_pt;
	longint cycles;
	bit hold_off, rx_idle_off;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic logic signed [7:0] scaled_dir(longint diff, longint d2);
		longint num, q;
		num = (diff < 0 ? -diff : diff) * 120;
		q = 0;
		while (q < 120 && (q + 1) * (q + 1) * d2 <= num * num)
			q++;
		return 8'(diff < 0 ? -q : q);
	endfunction

	function automatic slot_word_t bind_light(light_req_t q);
		slot_word_t w;
		longint r2, d2, dfx, dfy, dfz;
		w = '{ST_SKIP, 3'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0};
		if (q.rt == REQ_CLEAR) begin
			used_slots = 0;
			w.st = ST_CLEAR;
		end else if (q.rt == REQ_POINT) begin
			if (q.rp && q.rad >= 1) begin
				dfx = longint'(q.lx) - q.rx;
				dfy = longint'(q.ly) - q.ry;
				dfz = longint'(q.lz) - q.rz;
				d2 = dfx * dfx + dfy * dfy + dfz * dfz;
				r2 = longint'(q.rad) * q.rad;
				if (r2 > d2) begin
					if (used_slots >= MAX_SLOTS) w.st = ST_FULL;
					else begin
						w.st = ST_BOUND;
						w.slot = used_slots;
						used_slots++;
						w.r = 8'(q.cr * (r2 - d2) / r2);
						w.g = 8'(q.cg * (r2 - d2) / r2);
						w.b = 8'(q.cb * (r2 - d2) / r2);
						if (d2 != 0) begin
							w.dx = scaled_dir(dfx, d2);
							w.dy = scaled_dir(dfy, d2);
							w.dz = scaled_dir(dfz, d2);
						end
					end
				end
			end
		end else if (q.rt == REQ_DIR) begin
			if (used_slots >= MAX_SLOTS) w.st = ST_FULL;
			else begin
				w.st = ST_BOUND;
				w.slot = used_slots;
				used_slots++;
				w.r = q.cr; w.g = q.cg; w.b = q.cb;
				w.dx = q.lx[7:0]; w.dy = q.ly[7:0]; w.dz = q.lz[7:0];
			end
		end
		return w;
	endfunction

	task automatic send_req(light_req_t q, bit idle);
		while (idle && $urandom_range(99) < 29) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= q.rt; light_x <= q.lx; light_y <= q.ly; light_z <= q.lz;
		color_r <= q.cr; color_g <= q.cg; color_b <= q.cb;
		light_radius <= q.rad; ref_present <= q.rp;
		ref_x <= q.rx; ref_y <= q.ry; ref_z <= q.rz;
		bound_q.push_back(bind_light(q));
		if (q.rt == REQ_POINT) n_pt++;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	function automatic light_req_t rand_req();
		light_req_t q;
		int m;
		q.rt = $urandom_range(99) < 10 ? 2'($urandom_range(3)) :
			($urandom_range(99) < 12 ? REQ_CLEAR :
			($urandom_range(1) ? REQ_POINT : REQ_DIR));
		q.lx = 16'($urandom); q.ly = 16'($urandom); q.lz = 16'($urandom);
		q.cr = 8'($urandom); q.cg = 8'($urandom); q.cb = 8'($urandom);
		q.rad = 16'($urandom); q.rp = $urandom_range(99) < 90;
		q.rx = 16'($urandom); q.ry = 16'($urandom); q.rz = 16'($urandom);
		m = $urandom_range(3);
		if (m != 0) begin
			// keep the light near the reference; with m == 3 put it at the far end of the x range
			q.rad = 16'($urandom_range(m == 1 ? 40 : 32767, 1));
			q.lx = 16'(q.rx + $signed($urandom_range(2 * 60, 0)) - 60);
			q.ly = 16'(q.ry + $signed($urandom_range(2 * 60, 0)) - 60);
			q.lz = 16'(q.rz + $signed($urandom_range(2 * 60, 0)) - 60);
			if (m == 3) begin
				q.rx = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
				q.lx = 16'(-q.rx - 1);
			end
		end
		return q;
	endfunction

	light_req_t dir_tab[] = '{
		'{REQ_POINT, 16'sd5, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255, 16'sd10, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_POINT, 16'sd0, 16'sd0, 16'sd0, 8'd255, 8'd128, 8'd1, 16'sd1, 1'b1,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_POINT, 16'sd3, 16'sd4, 16'sd0, 8'd200, 8'd100, 8'd50, 16'sd10, 1'b1,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_POINT, 16'sd10, 16'sd0, 16'sd0, 8'd255, 8'd0, 8'd0, 16'sd10, 1'b1,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_POINT, 16'sd0, 16'sd0, 16'sd0, 8'd9, 8'd9, 8'd9, 16'sd0, 1'b1,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_POINT, 16'sd0, 16'sd0, 16'sd0, 8'd9, 8'd9, 8'd9, -16'sd32768, 1'b1,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_POINT, 16'sh7fff, -16'sh8000, 16'sh7fff, 8'd255, 8'd255, 8'd255,
			16'sh7fff, 1'b1, 16'sh7fff, -16'sh7fff, 16'sh7ff0},
		'{REQ_POINT, 16'sh7fff, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255,
			16'sh7fff, 1'b1, -16'sh8000, 16'sd0, 16'sd0},
		'{REQ_DIR, 16'sh7f80, 16'sh007f, -16'sd1, 8'd255, 8'd0, 8'd170, 16'sd0, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_DIR, 16'sd0, 16'sd0, 16'sd0, 8'd1, 8'd2, 8'd3, 16'sd0, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{2'd3, -16'sd1, -16'sd1, -16'sd1, 8'd255, 8'd255, 8'd255, 16'sh7fff, 1'b1,
			-16'sd1, -16'sd1, -16'sd1},
		'{REQ_DIR, 16'sd1, 16'sd1, 16'sd1, 8'd7, 8'd7, 8'd7, 16'sd0, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_DIR, 16'sd2, 16'sd2, 16'sd2, 8'd7, 8'd7, 8'd7, 16'sd0, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_DIR, 16'sd3, 16'sd3, 16'sd3, 8'd7, 8'd7, 8'd7, 16'sd0, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_DIR, 16'sd4, 16'sd4, 16'sd4, 8'd7, 8'd7, 8'd7, 16'sd0, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_DIR, 16'sd5, 16'sd5, 16'sd5, 8'd7, 8'd7, 8'd7, 16'sd0, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_DIR, 16'sd6, 16'sd6, 16'sd6, 8'd7, 8'd7, 8'd7, 16'sd0, 1'b0,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_POINT, 16'sd1, 16'sd0, 16'sd0, 8'd7, 8'd7, 8'd7, 16'sd9, 1'b1,
			16'sd0, 16'sd0, 16'sd0},
		'{REQ_CLEAR, 16'sd0, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255, 16'sd9, 1'b1,
			16'sd0, 16'sd0, 16'sd0}
	};
	// typed-in results: skipped rows, one copied directional row, full group, clear
	slot_word_t typed_tab[int] = '{
		0: '{ST_SKIP, 3'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0},
		3: '{ST_SKIP, 3'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0},
		4: '{ST_SKIP, 3'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0},
		5: '{ST_SKIP, 3'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0},
		8: '{ST_BOUND, 3'd3, 8'd255, 8'd0, 8'd170, -8'sd128, 8'sd127, -8'sd1},
		10: '{ST_SKIP, 3'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0},
		17: '{ST_FULL, 3'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0},
		18: '{ST_CLEAR, 3'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0}
	};

	// receiver: random stall, a quiet stretch and one long hold-off
	always @(posedge clk) begin
		if (hold_off) res_stall <= 1'b1;
		else if (rx_idle_off) res_stall <= 1'b0;
		else res_stall <= $urandom_range(99) < 29;
	end

	always @(posedge clk) begin
		slot_word_t e;
		cycles++;
		if (cycles > 64'd2000000) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && res_valid && !res_stall) begin
			n_seen++;
			if (bound_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = bound_q.pop_front();
				if (status == ST_BOUND) n_bound++;
				if (status == ST_FULL) n_full++;
				if (status !== e.st) begin $error("status exp %0d got %0d", e.st, status); errors++; end
				if (slot_index !== e.slot) begin
					$error("slot_index exp %0d got %0d", e.slot, slot_index); errors++;
				end
				if (out_r !== e.r) begin $error("out_r exp %0d got %0d", e.r, out_r); errors++; end
				if (out_g !== e.g) begin $error("out_g exp %0d got %0d", e.g, out_g); errors++; end
				if (out_b !== e.b) begin $error("out_b exp %0d got %0d", e.b, out_b); errors++; end
				if (dir_x !== e.dx) begin $error("dir_x exp %0d got %0d", e.dx, dir_x); errors++; end
				if (dir_y !== e.dy) begin $error("dir_y exp %0d got %0d", e.dy, dir_y); errors++; end
				if (dir_z !== e.dz) begin $error("dir_z exp %0d got %0d", e.dz, dir_z); errors++; end
			end
		end
	end

	initial begin
		slot_word_t p;
		errors = 0; n_seen = 0; n_bound = 0; n_full = 0; n_pt = 0; cycles = 0;
		used_slots = 0; hold_off = 0; rx_idle_off = 0;
		arst_n = 1'b0; req_valid = 1'b0; res_stall = 1'b0; req_type = REQ_CLEAR;
		light_x = 0; light_y = 0; light_z = 0; color_r = 0; color_g = 0; color_b = 0;
		light_radius = 0; ref_present = 0; ref_x = 0; ref_y = 0; ref_z = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			send_req(dir_tab[i], 1'b1);
			if (typed_tab.exists(i)) begin
				p = bound_q[$];
				if (p != typed_tab[i]) begin
					$error("row %0d: calculator disagrees with typed result", i);
					errors++;
				end
				bound_q[$] = typed_tab[i];
			end
		end
		for (int k = 0; k < 1800; k++) begin
			if (k == 400) hold_off = 1'b1;
			if (k == 800) rx_idle_off = 1'b1;
			if (k == 1100) rx_idle_off = 1'b0;
			if (k == 1400) begin
				// pause the sender until the block has drained
				req_valid <= 1'b0;
				while (bound_q.size() != 0) @(posedge clk);
			end
			send_req(rand_req(), !(k >= 800 && k < 1100));
		end
		req_valid <= 1'b0;
		while (bound_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		$display("Checked %0d result words: %0d point requests, %0d bound, %0d full group.",
			n_seen, n_pt, n_bound, n_full);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	// long receiver hold-off, counted in its own process
	initial begin
		wait (hold_off);
		repeat (600) @(posedge clk);
		hold_off = 1'b0;
	end

endmodule
